### src/rmm_pkg.sv
// shared types and constants for the running min/max/mean/std-dev unit
// no dependencies
package rmm_pkg;

  localparam logic [6:0] CLAMP_LIMIT = 7'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DIV_MEAN,
    ST_DIFF,
    ST_SQRT,
    ST_SD_LOAD,
    ST_DIV_SD,
    ST_DONE
  } state_t;

  // handshake between the sequencer and the top level
  typedef struct packed {
    logic idle;
    logic done;
  } core_ctl_t;

  // one result beat, fields in output order
  typedef struct packed {
    logic [13:0] std_dev_q8;
    logic [14:0] mean_q8;
    logic [6:0]  max_value;
    logic [6:0]  min_value;
    logic [7:0]  entry_count;
    logic        was_clamped;
    logic        accepted;
  } result_t;

endpackage

### src/running_min_max_mean_stddev_unit.sv
// Running min/max/mean/std-dev over percentage samples. Each input beat is one
// 7-bit sample (clamped to 100); each produces one result beat with the count,
// min, max, mean and population standard deviation (both with FRAC_BITS
// fraction bits, truncated). A single compare-subtract unit retires one
// quotient or root bit per cycle across the mean division, the square root
// and the final division by the count, after two passes through one shared
// multiplier. s_tready is high only while the sequencer is idle; a finished
// result waits in the output register.
// depends on rmm_pkg, rmm_stats, rmm_core
module running_min_max_mean_stddev_unit #(
  parameter int MAX_ENTRIES = 128,
  parameter int FRAC_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [6:0] sample_value
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] accepted, [1] was_clamped, [9:2] entry_count, [16:10] min_value,
  // [23:17] max_value, [38:24] mean_q8, [52:39] std_dev_q8
  output logic [55:0] m_tdata
);
  import rmm_pkg::*;

  localparam longint unsigned DMAX =
    64'd10000 * 64'(MAX_ENTRIES) * 64'(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = $clog2(100 * MAX_ENTRIES + 1);
  localparam int QW = $clog2(10000 * MAX_ENTRIES + 1);
  localparam int DW = $clog2(DMAX + 1);
  localparam int DP = (DW + 1) / 2;
  localparam int RB = DP + FRAC_BITS;
  localparam int MW = SW + FRAC_BITS;
  localparam int N1 = (MW > 2*DP) ? MW : 2*DP;
  localparam int NW = (N1 > RB) ? N1 : RB;
  localparam int UW = (RB + 2 > CW + 1) ? RB + 2 : CW + 1;
  localparam int IW = $clog2((MW > RB) ? MW : RB);

  logic          s_beat;
  logic          out_free;
  logic [CW-1:0] count;
  logic [6:0]    min_value;
  logic [6:0]    max_value;
  logic [SW-1:0] sum;
  logic [QW-1:0] sum_sq;
  logic          accepted;
  logic          was_clamped;
  core_ctl_t     ctl;
  logic [14:0]   mean_q8;
  logic [13:0]   std_dev_q8;
  result_t       res;

  assign s_tready = ctl.idle;
  assign s_beat   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  rmm_stats #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .CW          (CW),
    .SW          (SW),
    .QW          (QW)
  ) u_stats (
    .clk          (clk),
    .rst          (rst),
    .upd          (s_beat),
    .sample_value (s_tdata[6:0]),
    .count        (count),
    .min_value    (min_value),
    .max_value    (max_value),
    .sum          (sum),
    .sum_sq       (sum_sq),
    .accepted     (accepted),
    .was_clamped  (was_clamped)
  );

  rmm_core #(
    .FRAC_BITS (FRAC_BITS),
    .CW        (CW),
    .SW        (SW),
    .QW        (QW),
    .DW        (DW),
    .DP        (DP),
    .RB        (RB),
    .MW        (MW),
    .NW        (NW),
    .UW        (UW),
    .IW        (IW)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (s_beat),
    .out_free   (out_free),
    .count      (count),
    .sum        (sum),
    .sum_sq     (sum_sq),
    .ctl        (ctl),
    .mean_q8    (mean_q8),
    .std_dev_q8 (std_dev_q8)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      res.accepted    <= accepted;
      res.was_clamped <= was_clamped;
      res.entry_count <= 8'(count);
      res.min_value   <= min_value;
      res.max_value   <= max_value;
      res.mean_q8     <= mean_q8;
      res.std_dev_q8  <= std_dev_q8;
    end
  end

  assign m_tdata = 56'(res);

endmodule

### src/rmm_cmpsub.sv
// shared compare-and-subtract unit used by every division and square root step
// no dependencies
module rmm_cmpsub #(
  parameter int W = 24
) (
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  output logic         ge,
  output logic [W-1:0] diff
);

  logic [W:0] wide;

  assign wide = {1'b0, x} - {1'b0, y};
  assign ge   = ~wide[W];
  assign diff = wide[W-1:0];

endmodule

### src/rmm_stats.sv
// accumulator registers: count, min, max, sum and sum of squares, plus clamp
// depends on rmm_pkg
module rmm_stats #(
  parameter int MAX_ENTRIES = 128,
  parameter int CW = 8,
  parameter int SW = 14,
  parameter int QW = 21
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          upd,
  input  logic [6:0]    sample_value,
  output logic [CW-1:0] count,
  output logic [6:0]    min_value,
  output logic [6:0]    max_value,
  output logic [SW-1:0] sum,
  output logic [QW-1:0] sum_sq,
  output logic          accepted,
  output logic          was_clamped
);
  import rmm_pkg::*;

  logic [6:0]  v;
  logic        over;
  logic [13:0] vv;
  logic        room;

  assign over = sample_value > CLAMP_LIMIT;
  assign v    = over ? CLAMP_LIMIT : sample_value;
  assign vv   = 14'(v) * 14'(v);
  assign room = count < CW'(MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      min_value   <= '0;
      max_value   <= '0;
      sum         <= '0;
      sum_sq      <= '0;
      accepted    <= 1'b0;
      was_clamped <= 1'b0;
    end else if (upd) begin
      was_clamped <= over;
      accepted    <= room;
      if (room) begin
        // first value loads both extremes
        if (count == '0 || v < min_value) min_value <= v;
        if (count == '0 || v > max_value) max_value <= v;
        count  <= count + CW'(1);
        sum    <= sum + SW'(v);
        sum_sq <= sum_sq + QW'(vv);
      end
    end
  end

endmodule

### src/rmm_core.sv
// sequencer with one shared multiplier and one shared compare-subtract unit
// computes mean and std dev; depends on rmm_pkg and rmm_cmpsub
module rmm_core #(
  parameter int FRAC_BITS = 8,
  parameter int CW = 8,
  parameter int SW = 14,
  parameter int QW = 21,
  parameter int DW = 28,
  parameter int DP = 14,
  parameter int RB = 22,
  parameter int MW = 22,
  parameter int NW = 28,
  parameter int UW = 24,
  parameter int IW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          out_free,
  input  logic [CW-1:0] count,
  input  logic [SW-1:0] sum,
  input  logic [QW-1:0] sum_sq,
  output rmm_pkg::core_ctl_t ctl,
  output logic [14:0]   mean_q8,
  output logic [13:0]   std_dev_q8
);
  import rmm_pkg::*;

  localparam int XW = (CW > SW) ? CW : SW;
  localparam int YW = (QW > SW) ? QW : SW;

  state_t state, state_next;

  logic [IW-1:0]    step;
  logic [NW-1:0]    num;
  logic [UW-1:0]    rem;
  logic [RB-1:0]    root;
  logic [DW-1:0]    a_reg;
  logic [DW-1:0]    b_reg;
  logic [14:0]      mean_reg;

  logic [XW-1:0]    op_x;
  logic [YW-1:0]    op_y;
  logic [XW+YW-1:0] mul;
  logic [UW-1:0]    cs_x;
  logic [UW-1:0]    cs_y;
  logic             cs_ge;
  logic [UW-1:0]    cs_diff;
  logic [DW-1:0]    d;
  logic             last_mean;
  logic             last_root;

  // shared multiplier: count * sum_sq, then sum * sum
  always_comb begin
    if (state == ST_MUL_A) begin
      op_x = XW'(count);
      op_y = YW'(sum_sq);
    end else begin
      op_x = XW'(sum);
      op_y = YW'(sum);
    end
  end
  assign mul = (XW+YW)'(op_x) * (XW+YW)'(op_y);

  assign d = (a_reg > b_reg) ? (a_reg - b_reg) : '0;

  // division brings down one bit, square root one bit pair
  always_comb begin
    if (state == ST_SQRT) begin
      cs_x = {rem[UW-3:0], num[NW-1:NW-2]};
      cs_y = UW'({root, 2'b01});
    end else begin
      cs_x = {rem[UW-2:0], num[NW-1]};
      cs_y = UW'(count);
    end
  end

  rmm_cmpsub #(.W(UW)) u_cmpsub (
    .x    (cs_x),
    .y    (cs_y),
    .ge   (cs_ge),
    .diff (cs_diff)
  );

  assign last_mean = step == IW'(MW - 1);
  assign last_root = step == IW'(RB - 1);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl.idle   = 1'b0;
    ctl.done   = 1'b0;
    case (state)
      ST_IDLE: begin
        ctl.idle = 1'b1;
        if (start) state_next = ST_MUL_A;
      end
      ST_MUL_A:    state_next = ST_MUL_B;
      ST_MUL_B:    state_next = ST_DIV_MEAN;
      ST_DIV_MEAN: if (last_mean) state_next = ST_DIFF;
      ST_DIFF:     state_next = ST_SQRT;
      ST_SQRT:     if (last_root) state_next = ST_SD_LOAD;
      ST_SD_LOAD:  state_next = ST_DIV_SD;
      ST_DIV_SD:   if (last_root) state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          ctl.done   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_MUL_A: begin
        a_reg <= mul[DW-1:0];
        num   <= NW'({sum, {FRAC_BITS{1'b0}}}) << (NW - MW);
        rem   <= '0;
        step  <= '0;
      end
      ST_MUL_B: b_reg <= mul[DW-1:0];
      ST_DIV_MEAN, ST_DIV_SD: begin
        rem  <= cs_ge ? cs_diff : cs_x;
        num  <= {num[NW-2:0], cs_ge};
        step <= step + IW'(1);
      end
      ST_DIFF: begin
        mean_reg <= 15'(num[MW-1:0]);
        num      <= NW'((2*DP)'(d)) << (NW - 2*DP);
        rem      <= '0;
        root     <= '0;
        step     <= '0;
      end
      ST_SQRT: begin
        rem  <= cs_ge ? cs_diff : cs_x;
        root <= {root[RB-2:0], cs_ge};
        num  <= num << 2;
        step <= step + IW'(1);
      end
      ST_SD_LOAD: begin
        num  <= NW'(root) << (NW - RB);
        rem  <= '0;
        step <= '0;
      end
      default: ;
    endcase
  end

  assign mean_q8    = mean_reg;
  assign std_dev_q8 = 14'(num[RB-1:0]);

endmodule

### verif/running_min_max_mean_stddev_unit_tb.sv
// testbench for running_min_max_mean_stddev_unit: directed table, then random samples,
// every result beat checked against a local running-statistics predictor
// depends on rmm_pkg and running_min_max_mean_stddev_unit
module running_min_max_mean_stddev_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rmm_pkg::*;

  localparam int MAX_ENTRIES  = 128;
  localparam int FRAC_BITS    = 8;
  localparam int RANDOM_BEATS = 1800;
  localparam int PHASE_BEATS  = RANDOM_BEATS / 3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int DIRECTED_ROWS = 13;

  typedef struct {
    logic [6:0] sample;
    bit         fixed;   // expected result given in the row
    result_t    want;
  } stim_row_t;

  // first two rows: clamped first sample, then a zero; all others go to the predictor
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{7'd127, 1'b1, '{std_dev_q8: 14'd0, mean_q8: 15'd25600, max_value: 7'd100,
                       min_value: 7'd100, entry_count: 8'd1, was_clamped: 1'b1,
                       accepted: 1'b1}},
    '{7'd0, 1'b1, '{std_dev_q8: 14'd12800, mean_q8: 15'd12800, max_value: 7'd100,
                     min_value: 7'd0, entry_count: 8'd2, was_clamped: 1'b0,
                     accepted: 1'b1}},
    '{7'd101, 1'b0, '0},
    '{7'd100, 1'b0, '0},
    '{7'd1,   1'b0, '0},
    '{7'd64,  1'b0, '0},
    '{7'd63,  1'b0, '0},
    '{7'd50,  1'b0, '0},
    '{7'd99,  1'b0, '0},
    '{7'd102, 1'b0, '0},
    '{7'd0,   1'b0, '0},
    '{7'd85,  1'b0, '0},
    '{7'd42,  1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  int src_idle_pct = 28;
  int snk_idle_pct = 47;
  int mismatches = 0;
  int cycles = 0;

  // running statistics as the block should hold them
  int unsigned       held_count = 0;
  logic [6:0]        held_min = '0;
  logic [6:0]        held_max = '0;
  longint unsigned   held_sum = 0;
  longint unsigned   held_sum_sq = 0;

  result_t expected_stats[$];

  running_min_max_mean_stddev_unit #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("running_min_max_mean_stddev_unit_tb failed");
      $finish;
    end
  end

  // bitwise integer square root, two bits of the operand per step
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned trial;
    rem = 0;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((x >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // folds one sample into the running statistics and returns the result beat
  function automatic result_t fold_sample(input logic [6:0] raw);
    result_t         r;
    logic [6:0]      v;
    longint unsigned n;
    longint unsigned spread;
    longint unsigned sq_sum;
    r = '0;
    v = raw;
    if (raw > CLAMP_LIMIT) begin
      v = CLAMP_LIMIT;
      r.was_clamped = 1'b1;
    end
    if (held_count < MAX_ENTRIES) begin
      r.accepted = 1'b1;
      if (held_count == 0) begin
        held_min = v;
        held_max = v;
      end else begin
        if (v < held_min) held_min = v;
        if (v > held_max) held_max = v;
      end
      held_count++;
      held_sum += v;
      held_sum_sq += longint'(v) * longint'(v);
    end
    r.entry_count = 8'(held_count);
    r.min_value = held_min;
    r.max_value = held_max;
    if (held_count != 0) begin
      n = held_count;
      sq_sum = held_sum * held_sum;
      spread = (n * held_sum_sq > sq_sum) ? n * held_sum_sq - sq_sum : 0;
      r.mean_q8 = 15'((held_sum << FRAC_BITS) / n);
      r.std_dev_q8 = 14'(floor_sqrt(spread << (2 * FRAC_BITS)) / n);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // one input beat with random leading gaps; expectation queued on acceptance
  task automatic send_sample(input logic [6:0] v, input bit fixed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, v};
    do @(posedge clk); while (!s_tready);
    predicted = fold_sample(v);
    expected_stats.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[52:0];
      if (expected_stats.size() == 0) begin
        report_mismatch("unexpected result beat, entry_count", got.entry_count, -1);
      end else begin
        want = expected_stats.pop_front();
        if (got.accepted != want.accepted)
          report_mismatch("accepted", got.accepted, want.accepted);
        if (got.was_clamped != want.was_clamped)
          report_mismatch("was_clamped", got.was_clamped, want.was_clamped);
        if (got.entry_count != want.entry_count)
          report_mismatch("entry_count", got.entry_count, want.entry_count);
        if (got.min_value != want.min_value)
          report_mismatch("min_value", got.min_value, want.min_value);
        if (got.max_value != want.max_value)
          report_mismatch("max_value", got.max_value, want.max_value);
        if (got.mean_q8 != want.mean_q8)
          report_mismatch("mean_q8", got.mean_q8, want.mean_q8);
        if (got.std_dev_q8 != want.std_dev_q8)
          report_mismatch("std_dev_q8", got.std_dev_q8, want.std_dev_q8);
      end
    end
  end

  initial begin
    logic [6:0] v;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_sample(directed_rows[i].sample, directed_rows[i].fixed, directed_rows[i].want);

    // the store fills early in this part; later samples exercise the full-store path
    for (int k = 0; k < RANDOM_BEATS; k++) begin
      if (k == PHASE_BEATS) begin
        src_idle_pct = 47;
        snk_idle_pct = 28;
      end else if (k == 2 * PHASE_BEATS) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case ($urandom_range(9))
        0: v = 7'd0;
        1: v = 7'd100;
        2: v = 7'($urandom_range(127, 101));
        3: v = 7'($urandom_range(3));
        4: v = 7'($urandom_range(100, 96));
        default: v = 7'($urandom_range(127));
      endcase
      send_sample(v, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (expected_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("running_min_max_mean_stddev_unit_tb passed");
    end else begin
      $display("running_min_max_mean_stddev_unit_tb failed");
    end
    $finish;
  end

endmodule
